// ===== sv/hia_pkg.sv =====
package hia_pkg;

    localparam int DATA_W       = 32;
    localparam int ID_W         = 8;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 256;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_GET        = 3'd1;
    localparam logic [OP_W-1:0] OP_SET        = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

endpackage

// ===== sv/handle_id_allocator.sv =====
// add from the free stack: stack read, then slot write; get: slot read, then result; remove: slot
// read, then clear and id push; add of a fresh id, set, clear and rejected words end on acceptance
// find, find_first read one slot per cycle, slots 1 to high-water - 1; result strobe follows last step
// throughput: one word at a time, busy stays high until the result is produced; no stall from receiver
// reset (synchronous, active low): high-water 1, free count 0, memories keep contents, no clearing pass
module handle_id_allocator #(
    parameter int CAPACITY = hia_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [hia_pkg::OP_W-1:0]   i_opcode,
    input  logic [hia_pkg::ID_W-1:0]   i_slot_id,
    input  logic [hia_pkg::DATA_W-1:0] i_data_word,
    output logic                       o_valid,
    output logic [hia_pkg::ID_W-1:0]   o_result_id,
    output logic [hia_pkg::DATA_W-1:0] o_result_data,
    output logic [hia_pkg::ST_W-1:0]   o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_POP,
        S_REM,
        S_SCAN
    } t_state;

    t_state                     r_state, n_state;
    logic [hia_pkg::OP_W-1:0]   r_op, n_op;
    logic [AW-1:0]              r_id, n_id;
    logic [hia_pkg::DATA_W-1:0] r_data, n_data;
    logic [CW-1:0]              r_hw, n_hw;
    logic [CW-1:0]              r_fc, n_fc;
    logic [CW-1:0]              r_chk, n_chk;
    logic                       r_valid, n_valid;
    logic [hia_pkg::ID_W-1:0]   r_result_id, n_result_id;
    logic [hia_pkg::DATA_W-1:0] r_result_data, n_result_data;
    logic [hia_pkg::ST_W-1:0]   r_status, n_status;

    logic                       slot_we;
    logic [AW-1:0]              slot_waddr;
    logic [hia_pkg::DATA_W-1:0] slot_wdata;
    logic [AW-1:0]              slot_raddr;
    logic [hia_pkg::DATA_W-1:0] slot_rdata;

    logic                       stk_we;
    logic [AW-1:0]              stk_waddr;
    logic [hia_pkg::ID_W-1:0]   stk_wdata;
    logic [AW-1:0]              stk_raddr;
    logic [hia_pkg::ID_W-1:0]   stk_rdata;

    logic                       accept;
    logic                       id_ok;
    logic                       hw_room;
    logic                       fc_room;
    logic                       hit;

    hia_ram #(
        .WIDTH(hia_pkg::DATA_W),
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(slot_raddr),
        .o_rdata(slot_rdata)
    );

    hia_ram #(
        .WIDTH(hia_pkg::ID_W),
        .DEPTH(CAPACITY)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign accept  = start && (r_state == S_IDLE);
    assign id_ok   = (i_slot_id != '0) && (32'(i_slot_id) < 32'(r_hw));
    assign hw_room = 32'(r_hw) < 32'(CAPACITY);
    assign fc_room = 32'(r_fc) < 32'(CAPACITY);
    assign hit     = (r_op == hia_pkg::OP_FIND) ? (slot_rdata == r_data) : (slot_rdata != '0);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_id          = r_id;
        n_data        = r_data;
        n_hw          = r_hw;
        n_fc          = r_fc;
        n_chk         = r_chk;
        n_valid       = 1'b0;
        n_result_id   = '0;
        n_result_data = '0;
        n_status      = hia_pkg::ST_OK;
        slot_we       = 1'b0;
        slot_waddr    = r_id;
        slot_wdata    = r_data;
        slot_raddr    = r_id;
        stk_we        = 1'b0;
        stk_waddr     = AW'(r_fc);
        stk_wdata     = 8'(r_id);
        stk_raddr     = AW'(r_fc - CW'(1));

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_opcode;
                    n_id   = AW'(i_slot_id);
                    n_data = i_data_word;
                    case (i_opcode)
                        hia_pkg::OP_ADD: begin
                            if (r_fc != '0) begin
                                n_state = S_POP;
                            end else if (hw_room) begin
                                slot_we     = 1'b1;
                                slot_waddr  = AW'(r_hw);
                                slot_wdata  = i_data_word;
                                n_hw        = r_hw + CW'(1);
                                n_valid     = 1'b1;
                                n_result_id = 8'(r_hw);
                            end else begin
                                n_valid  = 1'b1;
                                n_status = hia_pkg::ST_FULL;
                            end
                        end
                        hia_pkg::OP_GET: begin
                            slot_raddr = AW'(i_slot_id);
                            if (id_ok) begin
                                n_state = S_GET;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = hia_pkg::ST_INVALID;
                            end
                        end
                        hia_pkg::OP_SET: begin
                            n_valid = 1'b1;
                            if (id_ok) begin
                                slot_we    = 1'b1;
                                slot_waddr = AW'(i_slot_id);
                                slot_wdata = i_data_word;
                            end else begin
                                n_status = hia_pkg::ST_INVALID;
                            end
                        end
                        hia_pkg::OP_REMOVE: begin
                            slot_raddr = AW'(i_slot_id);
                            if (id_ok) begin
                                n_state = S_REM;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = hia_pkg::ST_INVALID;
                            end
                        end
                        hia_pkg::OP_FIND, hia_pkg::OP_FIND_FIRST: begin
                            slot_raddr = AW'(1);
                            n_chk      = CW'(1);
                            if (r_hw == CW'(1)) begin
                                n_valid  = 1'b1;
                                n_status = hia_pkg::ST_INVALID;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        hia_pkg::OP_CLEAR: begin
                            n_hw    = CW'(1);
                            n_fc    = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = hia_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_POP: begin
                slot_we     = 1'b1;
                slot_waddr  = AW'(stk_rdata);
                n_fc        = r_fc - CW'(1);
                n_valid     = 1'b1;
                n_result_id = stk_rdata;
                n_state     = S_IDLE;
            end
            S_GET: begin
                n_valid       = 1'b1;
                n_result_data = slot_rdata;
                n_state       = S_IDLE;
            end
            S_REM: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (slot_rdata == '0) begin
                    n_status = hia_pkg::ST_INVALID;
                end else begin
                    slot_we       = 1'b1;
                    slot_wdata    = '0;
                    n_result_data = slot_rdata;
                    if (fc_room) begin
                        stk_we = 1'b1;
                        n_fc   = r_fc + CW'(1);
                    end
                end
            end
            S_SCAN: begin
                slot_raddr = AW'(r_chk + CW'(1));
                if (hit) begin
                    n_valid     = 1'b1;
                    n_result_id = 8'(r_chk);
                    n_state     = S_IDLE;
                end else if (r_chk == r_hw - CW'(1)) begin
                    n_valid  = 1'b1;
                    n_status = hia_pkg::ST_INVALID;
                    n_state  = S_IDLE;
                end else begin
                    n_chk = r_chk + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= CW'(1);
            r_fc    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_fc    <= n_fc;
            r_valid <= n_valid;
        end
        r_op          <= n_op;
        r_id          <= n_id;
        r_data        <= n_data;
        r_chk         <= n_chk;
        r_result_id   <= n_result_id;
        r_result_data <= n_result_data;
        r_status      <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_result_id   = r_result_id;
    assign o_result_data = r_result_data;
    assign o_status      = r_status;

endmodule

// ===== sv/hia_ram.sv =====
module hia_ram #(
    parameter int WIDTH = hia_pkg::DATA_W,
    parameter int DEPTH = hia_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
